>>> design/dshs_pkg.sv
package dshs_pkg;

	localparam int POSITION_BITS_DEF = 32;
	localparam int DELAY_BITS_DEF    = 16;

	// Widths fixed by the stream and register formats.
	localparam int CFG_DATA_BITS  = 16;
	localparam int CFG_INDEX_BITS = 3;
	localparam int MOVE_BITS      = 24;
	localparam int REM_BITS       = 24;
	localparam int POS_OUT_BITS   = 32;
	localparam int IN_DATA_BITS   = 32;
	localparam int OUT_DATA_BITS  = 40;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_HOME_DIR_NEG  = 3'd0,
		REG_FAST_DELAY    = 3'd1,
		REG_FINE_DELAY    = 3'd2,
		REG_RUN_DELAY     = 3'd3,
		REG_SEARCH_STEPS  = 3'd4,
		REG_BACKOFF_STEPS = 3'd5,
		REG_APPROACH_STEPS = 3'd6
	} reg_index_t;

	localparam logic [CFG_DATA_BITS-1:0] FAST_DELAY_RST    = 16'd200;
	localparam logic [CFG_DATA_BITS-1:0] FINE_DELAY_RST    = 16'd1000;
	localparam logic [CFG_DATA_BITS-1:0] RUN_DELAY_RST     = 16'd400;
	localparam logic [CFG_DATA_BITS-1:0] SEARCH_STEPS_RST  = 16'd1000;
	localparam logic [CFG_DATA_BITS-1:0] BACKOFF_STEPS_RST = 16'd500;
	localparam logic [CFG_DATA_BITS-1:0] APPROACH_STEPS_RST = 16'd50;

	typedef enum logic [1:0] {
		OP_NONE = 2'd0,
		OP_HOME = 2'd1,
		OP_MOVE = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_FAST     = 3'd1,
		PH_BACKOFF  = 3'd2,
		PH_APPROACH = 3'd3,
		PH_MOVE     = 3'd4
	} phase_t;

	typedef struct packed {
		logic                     home_dir_neg;
		logic [CFG_DATA_BITS-1:0] fast_delay;
		logic [CFG_DATA_BITS-1:0] fine_delay;
		logic [CFG_DATA_BITS-1:0] run_delay;
		logic [CFG_DATA_BITS-1:0] search_steps;
		logic [CFG_DATA_BITS-1:0] backoff_steps;
		logic [CFG_DATA_BITS-1:0] approach_steps;
	} cfg_t;

	typedef struct packed {
		logic signed [POS_OUT_BITS-1:0] position;
		logic                           homed;
		logic                           command_accepted;
		logic                           busy_res;
		logic                           top_direction;
		logic                           step_pulse;
	} result_t;

endpackage

>>> design/dshs_engine.sv
module dshs_engine import dshs_pkg::*; #(
	parameter int POSITION_BITS = POSITION_BITS_DEF,
	parameter int DELAY_BITS    = DELAY_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  op_t                         op,
	input  logic signed [MOVE_BITS-1:0] move_steps,
	input  logic                        sensor_hit,
	input  cfg_t                        cfg,
	output result_t                     res
);

	phase_t                     phase_q, phase_c;
	logic signed [REM_BITS-1:0] rem_q, rem_c;
	logic [DELAY_BITS-1:0]      dly_q, dly_c;
	logic [DELAY_BITS-1:0]      tc_q, tc_c;
	logic [POSITION_BITS-1:0]   pos_q, pos_c;
	logic                       accepted;
	logic                       homed;
	logic                       pulse;
	logic                       dir;
	logic [POS_OUT_BITS-1:0]    pos_out;

	function automatic logic signed [REM_BITS-1:0] load_block(
		input logic [CFG_DATA_BITS-1:0] cnt,
		input logic                     neg
	);
		logic signed [REM_BITS-1:0] mag;
		mag = REM_BITS'(cnt);
		return neg ? -mag : mag;
	endfunction

	// Command first, then the step engine, then the homing and move phase logic.
	always_comb begin
		phase_c  = phase_q;
		rem_c    = rem_q;
		dly_c    = dly_q;
		tc_c     = tc_q;
		pos_c    = pos_q;
		accepted = 1'b0;
		homed    = 1'b0;
		pulse    = 1'b0;

		if (phase_q == PH_IDLE && op == OP_HOME) begin
			dly_c    = DELAY_BITS'(cfg.fast_delay);
			rem_c    = load_block(cfg.search_steps, cfg.home_dir_neg);
			phase_c  = PH_FAST;
			accepted = 1'b1;
		end else if (phase_q == PH_IDLE && op == OP_MOVE) begin
			dly_c    = DELAY_BITS'(cfg.run_delay);
			rem_c    = REM_BITS'(move_steps);
			phase_c  = PH_MOVE;
			accepted = 1'b1;
		end

		dir = rem_c[REM_BITS-1];
		if (rem_c != '0) begin
			if (tc_c != '1)
				tc_c = tc_c + DELAY_BITS'(1);
			if (tc_c >= dly_c) begin
				tc_c  = '0;
				pulse = 1'b1;
				if (dir) begin
					pos_c = pos_c - POSITION_BITS'(1);
					rem_c = rem_c + REM_BITS'(1);
				end else begin
					pos_c = pos_c + POSITION_BITS'(1);
					rem_c = rem_c - REM_BITS'(1);
				end
			end
		end else begin
			tc_c = '0;
		end

		case (phase_c)
			PH_IDLE: begin
			end
			PH_FAST: begin
				if (sensor_hit) begin
					tc_c    = '0;
					dly_c   = DELAY_BITS'(cfg.fine_delay);
					rem_c   = load_block(cfg.backoff_steps, !cfg.home_dir_neg);
					phase_c = PH_BACKOFF;
				end else if (rem_c == '0) begin
					rem_c = load_block(cfg.search_steps, cfg.home_dir_neg);
				end
			end
			PH_BACKOFF: begin
				if (!sensor_hit) begin
					tc_c    = '0;
					rem_c   = load_block(cfg.approach_steps, cfg.home_dir_neg);
					phase_c = PH_APPROACH;
				end else if (rem_c == '0) begin
					rem_c = load_block(cfg.backoff_steps, !cfg.home_dir_neg);
				end
			end
			PH_APPROACH: begin
				if (sensor_hit) begin
					tc_c    = '0;
					rem_c   = '0;
					pos_c   = '0;
					phase_c = PH_IDLE;
					homed   = 1'b1;
				end else if (rem_c == '0) begin
					rem_c = load_block(cfg.approach_steps, cfg.home_dir_neg);
				end
			end
			PH_MOVE: begin
				if (rem_c == '0)
					phase_c = PH_IDLE;
			end
			default: begin
				phase_c = PH_IDLE;
			end
		endcase

		// Without a step the direction shows the sign of what is still queued.
		if (!pulse)
			dir = rem_c[REM_BITS-1];
	end

	generate
		if (POSITION_BITS >= POS_OUT_BITS) begin : g_pos_trunc
			assign pos_out = pos_c[POS_OUT_BITS-1:0];
		end else begin : g_pos_sext
			assign pos_out = {{(POS_OUT_BITS-POSITION_BITS){pos_c[POSITION_BITS-1]}}, pos_c};
		end
	endgenerate

	always_comb begin
		res.step_pulse       = pulse;
		res.top_direction    = dir;
		res.busy_res         = (phase_c != PH_IDLE);
		res.command_accepted = accepted;
		res.homed            = homed;
		res.position         = $signed(pos_out);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			rem_q   <= '0;
			dly_q   <= '0;
			tc_q    <= '0;
			pos_q   <= '0;
		end else if (en) begin
			phase_q <= phase_c;
			rem_q   <= rem_c;
			dly_q   <= dly_c;
			tc_q    <= tc_c;
			pos_q   <= pos_c;
		end
	end

	a_idle_no_steps: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> rem_q == '0)
		else $error("steps queued while idle");

	a_counter_held: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q == '0 |-> tc_q == '0)
		else $error("tick counter running with no steps queued");

	a_accept_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res.command_accepted |-> phase_q == PH_IDLE)
		else $error("command taken while busy");

	a_homed_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		(en && res.homed) |=> (pos_q == '0 && phase_q == PH_IDLE))
		else $error("homing finished without zeroed position");

endmodule

>>> design/dual_stepper_homing_sequencer_unit.sv
// Homing and move sequencer for two opposed steppers sharing one step count.
// Each input request is one microsecond tick carrying the sensor level and an
// optional command (tuser: none, home, move); each request yields exactly one
// result request. A tick is processed as it is accepted: the tick is applied to
// the phase, step counter and position registers and its result lands in the
// output register, so the block takes one request per clock, and the result is
// offered in the cycle after acceptance. The only limit on that rate is
// the output register: a new tick is taken whenever the result register is
// empty or is being drained in the same cycle. Configuration registers reset
// to their documented defaults and should be written only while the block is
// idle; writes to an index beyond the last register are ignored.
module dual_stepper_homing_sequencer_unit import dshs_pkg::*; #(
	parameter int POSITION_BITS = POSITION_BITS_DEF,
	parameter int DELAY_BITS    = DELAY_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,

	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	// [23:0] move_steps, [24] sensor_hit, [31:25] zero
	input  logic [IN_DATA_BITS-1:0]   s_axis_tdata,
	// [1:0] op
	input  logic [1:0]                s_axis_tuser,

	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	// [0] step_pulse, [1] top_direction, [2] busy_res, [3] command_accepted,
	// [4] homed, [36:5] position, [39:37] zero
	output logic [OUT_DATA_BITS-1:0]  m_axis_tdata,

	input  logic                      cfg_wr_en,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_wdata
);

	cfg_t    cfg_q;
	result_t res;
	result_t out_q;
	logic    out_valid_q;
	logic    accept;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.home_dir_neg   <= 1'b0;
			cfg_q.fast_delay     <= FAST_DELAY_RST;
			cfg_q.fine_delay     <= FINE_DELAY_RST;
			cfg_q.run_delay      <= RUN_DELAY_RST;
			cfg_q.search_steps   <= SEARCH_STEPS_RST;
			cfg_q.backoff_steps  <= BACKOFF_STEPS_RST;
			cfg_q.approach_steps <= APPROACH_STEPS_RST;
		end else if (cfg_wr_en) begin
			case (reg_index_t'(cfg_index))
				REG_HOME_DIR_NEG:   cfg_q.home_dir_neg   <= cfg_wdata[0];
				REG_FAST_DELAY:     cfg_q.fast_delay     <= cfg_wdata;
				REG_FINE_DELAY:     cfg_q.fine_delay     <= cfg_wdata;
				REG_RUN_DELAY:      cfg_q.run_delay      <= cfg_wdata;
				REG_SEARCH_STEPS:   cfg_q.search_steps   <= cfg_wdata;
				REG_BACKOFF_STEPS:  cfg_q.backoff_steps  <= cfg_wdata;
				REG_APPROACH_STEPS: cfg_q.approach_steps <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	dshs_engine #(
		.POSITION_BITS(POSITION_BITS),
		.DELAY_BITS   (DELAY_BITS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (accept),
		.op        (op_t'(s_axis_tuser)),
		.move_steps($signed(s_axis_tdata[MOVE_BITS-1:0])),
		.sensor_hit(s_axis_tdata[MOVE_BITS]),
		.cfg       (cfg_q),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			out_q <= res;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_DATA_BITS'(out_q);

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

import dshs_pkg::*;

class homing_scoreboard;
	cfg_t     regs;
	phase_t   ph;
	longint   steps_left;
	logic [DELAY_BITS_DEF-1:0]    step_delay;
	logic [DELAY_BITS_DEF-1:0]    tick_count;
	logic [POSITION_BITS_DEF-1:0] motor_pos;
	result_t  expected_ticks[$];
	int       err_count;

	function new();
		regs           = '0;
		regs.fast_delay     = FAST_DELAY_RST;
		regs.fine_delay     = FINE_DELAY_RST;
		regs.run_delay      = RUN_DELAY_RST;
		regs.search_steps   = SEARCH_STEPS_RST;
		regs.backoff_steps  = BACKOFF_STEPS_RST;
		regs.approach_steps = APPROACH_STEPS_RST;
		ph         = PH_IDLE;
		steps_left = 0;
		step_delay = '0;
		tick_count = '0;
		motor_pos  = '0;
		err_count  = 0;
	endfunction

	function void write_reg(reg_index_t idx, logic [CFG_DATA_BITS-1:0] value);
		case (idx)
			REG_HOME_DIR_NEG:   regs.home_dir_neg   = value[0];
			REG_FAST_DELAY:     regs.fast_delay     = value;
			REG_FINE_DELAY:     regs.fine_delay     = value;
			REG_RUN_DELAY:      regs.run_delay      = value;
			REG_SEARCH_STEPS:   regs.search_steps   = value;
			REG_BACKOFF_STEPS:  regs.backoff_steps  = value;
			REG_APPROACH_STEPS: regs.approach_steps = value;
			default: ;
		endcase
	endfunction

	// Toward home means the configured search direction; away is the opposite.
	function void load_block(logic [CFG_DATA_BITS-1:0] count, bit toward_home);
		if (regs.home_dir_neg == toward_home)
			steps_left = -longint'(count);
		else
			steps_left = longint'(count);
	endfunction

	function void halt();
		steps_left = 0;
		tick_count = '0;
	endfunction

	function void predict_tick(logic [1:0] op, logic [MOVE_BITS-1:0] move_steps, logic hit);
		result_t r;
		bit      dir;
		r = '0;
		if (ph == PH_IDLE && op == OP_HOME) begin
			step_delay = regs.fast_delay;
			load_block(regs.search_steps, 1'b1);
			ph = PH_FAST;
			r.command_accepted = 1'b1;
		end else if (ph == PH_IDLE && op == OP_MOVE) begin
			step_delay = regs.run_delay;
			steps_left = longint'($signed(move_steps));
			ph = PH_MOVE;
			r.command_accepted = 1'b1;
		end

		dir = steps_left < 0;
		if (steps_left != 0) begin
			if (tick_count != '1)
				tick_count++;
			if (tick_count >= step_delay) begin
				tick_count = '0;
				r.step_pulse = 1'b1;
				if (dir) begin
					motor_pos--;
					steps_left++;
				end else begin
					motor_pos++;
					steps_left--;
				end
			end
		end else begin
			tick_count = '0;
		end

		case (ph)
			PH_FAST: begin
				if (hit) begin
					halt();
					step_delay = regs.fine_delay;
					load_block(regs.backoff_steps, 1'b0);
					ph = PH_BACKOFF;
				end else if (steps_left == 0) begin
					load_block(regs.search_steps, 1'b1);
				end
			end
			PH_BACKOFF: begin
				if (!hit) begin
					halt();
					load_block(regs.approach_steps, 1'b1);
					ph = PH_APPROACH;
				end else if (steps_left == 0) begin
					load_block(regs.backoff_steps, 1'b0);
				end
			end
			PH_APPROACH: begin
				if (hit) begin
					halt();
					motor_pos = '0;
					ph = PH_IDLE;
					r.homed = 1'b1;
				end else if (steps_left == 0) begin
					load_block(regs.approach_steps, 1'b1);
				end
			end
			PH_MOVE: begin
				if (steps_left == 0)
					ph = PH_IDLE;
			end
			default: ph = PH_IDLE;
		endcase

		if (!r.step_pulse)
			dir = steps_left < 0;
		r.top_direction = dir;
		r.busy_res      = ph != PH_IDLE;
		r.position      = motor_pos;
		expected_ticks.push_back(r);
	endfunction

	task report_mismatch(string what, longint want, longint got);
		err_count++;
		$display("[%0t] mismatch in %s: expected %0d, got %0d", $realtime, what, want, got);
	endtask

	task check_result(logic [OUT_DATA_BITS-1:0] data);
		result_t got;
		result_t want;
		got = data[$bits(result_t)-1:0];
		if (expected_ticks.size() == 0) begin
			report_mismatch("unexpected result request", 0, longint'(got));
			return;
		end
		want = expected_ticks.pop_front();
		if (got.step_pulse !== want.step_pulse)
			report_mismatch("step_pulse", longint'(want.step_pulse),
				longint'(got.step_pulse));
		if (got.top_direction !== want.top_direction)
			report_mismatch("top_direction", longint'(want.top_direction),
				longint'(got.top_direction));
		if (got.busy_res !== want.busy_res)
			report_mismatch("busy_res", longint'(want.busy_res), longint'(got.busy_res));
		if (got.command_accepted !== want.command_accepted)
			report_mismatch("command_accepted", longint'(want.command_accepted),
				longint'(got.command_accepted));
		if (got.homed !== want.homed)
			report_mismatch("homed", longint'(want.homed), longint'(got.homed));
		if (got.position !== want.position)
			report_mismatch("position", longint'(want.position), longint'(got.position));
	endtask
endclass

module tb_top;
	localparam logic [1:0] OP_UNDEFINED = 2'd3;
	localparam int STALL_LIMIT = 2000;
	localparam int STYLE_TINY = 0, STYLE_SMALL = 1, STYLE_EXTREME = 2, STYLE_ANY = 3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_DATA_BITS-1:0] s_axis_tdata = '0;
	logic [1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_DATA_BITS-1:0] m_axis_tdata;
	logic cfg_wr_en = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

	homing_scoreboard sb = new();

	int burst_left = 0;
	int items_sent = 0;
	int idle_cycles = 0;
	int rx_mode = 0;
	int rx_left = 0;
	int rx_count = 0;

	dual_stepper_homing_sequencer_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Result side: check each accepted result, then pick the next ready level.
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;

		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 2);
			rx_left = $urandom_range(10, 200);
		end else begin
			rx_left--;
		end
		rx_count++;
		case (rx_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= $urandom_range(0, 2) != 0;
			default: m_axis_tready <= (rx_count % 4) == 0;
		endcase
	end

	initial begin
		while (idle_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("simulation failed");
		$finish;
	end

	task automatic send_tick(logic [1:0] op, logic [MOVE_BITS-1:0] move_steps, logic hit);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 9);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
			                                          : $urandom_range(1, 20);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(IN_DATA_BITS-MOVE_BITS-1){1'b0}}, hit, move_steps};
		s_axis_tuser  <= op;
		do @(posedge clk); while (!s_axis_tready);
		sb.predict_tick(op, move_steps, hit);
		burst_left--;
		items_sent++;
	endtask

	function automatic logic [1:0] random_op();
		case ($urandom_range(0, 9))
			0: return OP_HOME;
			1: return OP_MOVE;
			2: return OP_UNDEFINED;
			default: return OP_NONE;
		endcase
	endfunction

	// A move that would be taken is kept short enough to finish at the current run speed.
	function automatic logic [MOVE_BITS-1:0] pick_steps(logic [1:0] op);
		int lim;
		int v;
		if (op == OP_MOVE && sb.ph == PH_IDLE) begin
			lim = 3000 / (int'(sb.regs.run_delay) + 1);
			if (lim > 40)
				lim = 40;
			v = int'($urandom_range(0, 2 * lim)) - lim;
			return v[MOVE_BITS-1:0];
		end
		return MOVE_BITS'($urandom());
	endfunction

	// Sensor levels that walk any homing run or move to its end.
	task automatic finish_motion();
		logic [1:0] op;
		logic hit;
		while (sb.ph != PH_IDLE) begin
			op = random_op();
			case (sb.ph)
				PH_FAST, PH_APPROACH: hit = 1'b1;
				PH_BACKOFF:           hit = 1'b0;
				default:              hit = 1'($urandom_range(0, 1));
			endcase
			send_tick(op, pick_steps(op), hit);
		end
	endtask

	task automatic run_homing();
		int n;
		logic [1:0] op;
		n = $urandom_range(1, 40);
		finish_motion();
		send_tick(OP_HOME, pick_steps(OP_HOME), 1'b0);
		repeat ($urandom_range(0, n)) begin
			op = random_op();
			send_tick(op, pick_steps(op), 1'b0);
		end
		repeat ($urandom_range(1, n)) begin
			op = random_op();
			send_tick(op, pick_steps(op), 1'b1);
		end
		repeat ($urandom_range(1, n)) begin
			op = random_op();
			send_tick(op, pick_steps(op), 1'b0);
		end
		op = random_op();
		send_tick(op, pick_steps(op), 1'b1);
	endtask

	task automatic run_move();
		finish_motion();
		send_tick(OP_MOVE, pick_steps(OP_MOVE), 1'($urandom_range(0, 1)));
		finish_motion();
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (sb.expected_ticks.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_register(reg_index_t idx, logic [CFG_DATA_BITS-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		sb.write_reg(idx, value);
	endtask

	task automatic randomize_registers(int style);
		reg_index_t idx;
		logic [CFG_DATA_BITS-1:0] value;
		idx = idx.first();
		do begin
			case (style)
				STYLE_TINY:    value = CFG_DATA_BITS'($urandom_range(0, 3));
				STYLE_SMALL:   value = CFG_DATA_BITS'($urandom_range(1, 30));
				STYLE_EXTREME: value = ($urandom_range(0, 1) != 0) ? '1 : '0;
				STYLE_ANY:     value = CFG_DATA_BITS'($urandom());
				default:       value = '0;
			endcase
			write_register(idx, value);
			idx = idx.next();
		end while (idx != idx.first());
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		int target;
		int pick;
		reg_index_t idx;
		logic [1:0] op;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: idle ticks, undefined op, empty move, refused commands, full homing.
		send_tick(OP_NONE, 24'h7FFFFF, 1'b1);
		send_tick(OP_UNDEFINED, 24'h800000, 1'b0);
		send_tick(OP_MOVE, 24'h000000, 1'b0);
		send_tick(OP_HOME, 24'hFFFFFF, 1'b1);
		send_tick(OP_MOVE, 24'h800000, 1'b1);
		send_tick(OP_HOME, 24'h000000, 1'b1);
		send_tick(OP_UNDEFINED, 24'h7FFFFF, 1'b0);
		send_tick(OP_NONE, 24'h000000, 1'b1);

		// Zero fast and run delays and empty search and approach blocks, searching in the negative direction.
		wait_idle();
		write_register(REG_HOME_DIR_NEG, 16'h0001);
		write_register(REG_FAST_DELAY, 16'd0);
		write_register(REG_FINE_DELAY, 16'd1);
		write_register(REG_RUN_DELAY, 16'd0);
		write_register(REG_SEARCH_STEPS, 16'd0);
		write_register(REG_BACKOFF_STEPS, 16'd1);
		write_register(REG_APPROACH_STEPS, 16'd0);
		cfg_wr_en <= 1'b0;
		send_tick(OP_HOME, 24'h000000, 1'b0);
		send_tick(OP_NONE, 24'h000000, 1'b0);
		send_tick(OP_NONE, 24'h000000, 1'b1);
		repeat (3) send_tick(OP_NONE, 24'h000000, 1'b1);
		send_tick(OP_NONE, 24'h000000, 1'b0);
		send_tick(OP_NONE, 24'h000000, 1'b1);
		send_tick(OP_MOVE, 24'h000003, 1'b0);
		finish_motion();
		send_tick(OP_MOVE, 24'hFFFFFD, 1'b1);
		finish_motion();

		for (int p = 0; p < 5; p++) begin
			wait_idle();
			randomize_registers(p % 4);
			target = items_sent + 150;
			while (items_sent < target) begin
				pick = $urandom_range(0, 19);
				if (pick < 11) begin
					run_homing();
				end else if (pick < 17) begin
					run_move();
				end else begin
					repeat ($urandom_range(1, 15)) begin
						op = random_op();
						send_tick(op, pick_steps(op), 1'($urandom_range(0, 1)));
					end
				end
			end
			finish_motion();
		end

		// Largest settings: homing runs, then a move that stays busy on the long step delay.
		wait_idle();
		idx = idx.first();
		do begin
			write_register(idx, '1);
			idx = idx.next();
		end while (idx != idx.first());
		cfg_wr_en <= 1'b0;
		repeat (4) run_homing();
		finish_motion();
		send_tick(OP_MOVE, 24'h000001, 1'b0);
		repeat (20) send_tick(OP_NONE, 24'h000000, 1'b0);
		send_tick(OP_MOVE, 24'h800000, 1'b1);
		repeat (5) send_tick(OP_NONE, 24'h000000, 1'b0);

		s_axis_tvalid <= 1'b0;
		for (int i = 0; i < STALL_LIMIT && sb.expected_ticks.size() != 0; i++)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (sb.expected_ticks.size() != 0)
			sb.report_mismatch("results never arrived", longint'(sb.expected_ticks.size()), 0);
		if (sb.err_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
